/* hw/rtl/kss_pkg.sv */
package kss_pkg;

   localparam int VAL_W  = 32;
   localparam int SUM_W  = 33;
   localparam int RANK_W = 8;
   localparam int OP_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_TAKE   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

endpackage

/* hw/rtl/kss_ram.sv */
module kss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/k_smallest_pair_sums.sv */
// Loads (operations 0 and 1) are taken from idle; other codes without a take are dropped.
// A take pops the heap and pushes up to two pairs. The first take after a load also
// insertion-sorts both lists in RAM. Throughput is one transaction at a time. Synchronous
// reset clears counts, session and output valid; list and heap RAM contents stay undefined
// until written.
module k_smallest_pair_sums #(
   parameter int MAX_ITEMS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [kss_pkg::OP_W-1:0]             req_operation,
   input  logic signed [kss_pkg::VAL_W-1:0]     req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [kss_pkg::SUM_W-1:0]     rsp_sum,
   output logic [kss_pkg::RANK_W-1:0]           rsp_rank,
   output logic                                 rsp_last,
   output logic                                 rsp_status
);

   localparam int IW  = $clog2(MAX_ITEMS);
   localparam int CW  = $clog2(MAX_ITEMS + 1);
   localparam int HD  = 2 * MAX_ITEMS;
   localparam int HAW = $clog2(HD);
   localparam int HSW = $clog2(HD + 1);
   localparam int EW  = kss_pkg::SUM_W + 2 * IW;

   typedef struct packed {
      logic signed [kss_pkg::SUM_W-1:0] s;
      logic [IW-1:0]                    i;
      logic [IW-1:0]                    j;
   } entry_type;

   typedef enum logic [18:0] {
      ST_IDLE     = 19'd1,
      ST_SORT_RD  = 19'd2,
      ST_SORT_GET = 19'd4,
      ST_SORT_CMP = 19'd8,
      ST_SORT_PUT = 19'd16,
      ST_SEED     = 19'd32,
      ST_CHECK    = 19'd64,
      ST_POP_RD0  = 19'd128,
      ST_POP_RDL  = 19'd256,
      ST_POP_LAST = 19'd512,
      ST_POP_C1   = 19'd1024,
      ST_POP_C1D  = 19'd2048,
      ST_POP_C2D  = 19'd4096,
      ST_PUSH_SEL = 19'd8192,
      ST_PUSH_RD  = 19'd16384,
      ST_PUSH_SUM = 19'd32768,
      ST_PUSH_CMP = 19'd65536,
      ST_PUSH_PUT = 19'd131072,
      ST_RSP      = 19'd262144
   } state_type;

   function automatic logic entry_less(entry_type p, entry_type q);
      if (p.s != q.s) begin
         return $signed(p.s) < $signed(q.s);
      end else if (p.i != q.i) begin
         return p.i < q.i;
      end else begin
         return p.j < q.j;
      end
   endfunction

   state_type state_ff, state_in;
   logic [CW-1:0]  count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [CW-1:0]  emitted_ff, emitted_in;
   logic [HSW-1:0] heap_size_ff, heap_size_in;
   logic           sorted_ff, sorted_in;
   logic           seed_ff, seed_in;
   logic [1:0]     pend_ff, pend_in;
   logic           sel_b_ff, sel_b_in;
   logic [CW-1:0]  sk_ff, sk_in;
   logic [IW-1:0]  sm_ff, sm_in;
   logic signed [kss_pkg::VAL_W-1:0] sx_ff, sx_in;
   logic [IW-1:0]  pi_ff, pi_in, pj_ff, pj_in;
   logic [HAW-1:0] k_ff, k_in;
   entry_type      e_ff, e_in, top_ff, top_in, c1_ff, c1_in;
   logic [HAW+1:0] c_ff, c_in;
   logic           res_status_ff, res_status_in, res_last_ff, res_last_in;
   logic [kss_pkg::RANK_W-1:0] res_rank_ff, res_rank_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic signed [kss_pkg::SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic [kss_pkg::RANK_W-1:0] rsp_rank_ff, rsp_rank_in;
   logic           rsp_last_ff, rsp_last_in, rsp_status_ff, rsp_status_in;

   logic                     list_wr_a, list_wr_b;
   logic [IW-1:0]            list_wr_addr, a_rd_addr, b_rd_addr;
   logic [kss_pkg::VAL_W-1:0] list_wr_data, a_rd_data, b_rd_data;
   logic                     heap_wr_en;
   logic [HAW-1:0]           heap_wr_addr, heap_rd_addr;
   entry_type                heap_wr_data, heap_rd;
   logic [EW-1:0]            heap_rd_data;

   logic [CW-1:0]  n_pairs, cnt_sel;
   logic signed [kss_pkg::VAL_W-1:0] sdata;
   logic [HAW+1:0] child1, size_ext;
   logic [HAW-1:0] parent_k;
   logic signed [kss_pkg::SUM_W-1:0] push_sum;
   entry_type      push_e, best;
   logic [HAW+1:0] best_c;
   logic           out_free;

   kss_ram #(.WIDTH(kss_pkg::VAL_W), .DEPTH(MAX_ITEMS)) u_list_a (
      .clock(clock), .wr_en(list_wr_a), .wr_addr(list_wr_addr), .wr_data(list_wr_data),
      .rd_addr(a_rd_addr), .rd_data(a_rd_data));

   kss_ram #(.WIDTH(kss_pkg::VAL_W), .DEPTH(MAX_ITEMS)) u_list_b (
      .clock(clock), .wr_en(list_wr_b), .wr_addr(list_wr_addr), .wr_data(list_wr_data),
      .rd_addr(b_rd_addr), .rd_data(b_rd_data));

   kss_ram #(.WIDTH(EW), .DEPTH(HD)) u_heap (
      .clock(clock), .wr_en(heap_wr_en), .wr_addr(heap_wr_addr), .wr_data(heap_wr_data),
      .rd_addr(heap_rd_addr), .rd_data(heap_rd_data));

   assign heap_rd  = entry_type'(heap_rd_data);
   assign n_pairs  = (count_a_ff < count_b_ff) ? count_a_ff : count_b_ff;
   assign cnt_sel  = sel_b_ff ? count_b_ff : count_a_ff;
   assign sdata    = sel_b_ff ? $signed(b_rd_data) : $signed(a_rd_data);
   assign child1   = {1'b0, k_ff, 1'b1};
   assign size_ext = (HAW+2)'(heap_size_ff);
   assign parent_k = HAW'((k_ff - HAW'(1)) >> 1);
   assign push_sum = {a_rd_data[kss_pkg::VAL_W-1], a_rd_data}
                   + {b_rd_data[kss_pkg::VAL_W-1], b_rd_data};
   assign push_e   = '{s: push_sum, i: pi_ff, j: pj_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (state_ff == ST_POP_C2D && entry_less(heap_rd, c1_ff)) begin
         best   = heap_rd;
         best_c = c_ff + (HAW+2)'(1);
      end else if (state_ff == ST_POP_C2D) begin
         best   = c1_ff;
         best_c = c_ff;
      end else begin
         best   = heap_rd;
         best_c = c_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      emitted_in    = emitted_ff;
      heap_size_in  = heap_size_ff;
      sorted_in     = sorted_ff;
      seed_in       = seed_ff;
      pend_in       = pend_ff;
      sel_b_in      = sel_b_ff;
      sk_in         = sk_ff;
      sm_in         = sm_ff;
      sx_in         = sx_ff;
      pi_in         = pi_ff;
      pj_in         = pj_ff;
      k_in          = k_ff;
      e_in          = e_ff;
      top_in        = top_ff;
      c1_in         = c1_ff;
      c_in          = c_ff;
      res_status_in = res_status_ff;
      res_last_in   = res_last_ff;
      res_rank_in   = res_rank_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sum_in    = rsp_sum_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      list_wr_a     = 1'b0;
      list_wr_b     = 1'b0;
      list_wr_addr  = sm_ff;
      list_wr_data  = sx_ff;
      a_rd_addr     = pi_ff;
      b_rd_addr     = pj_ff;
      heap_wr_en    = 1'b0;
      heap_wr_addr  = k_ff;
      heap_wr_data  = e_ff;
      heap_rd_addr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (kss_pkg::op_type'(req_operation))
                  kss_pkg::OP_LOAD_A, kss_pkg::OP_LOAD_B: begin
                     list_wr_data = req_value;
                     if (req_operation == kss_pkg::OP_LOAD_A) begin
                        list_wr_addr = count_a_ff[IW-1:0];
                        if (count_a_ff < CW'(MAX_ITEMS)) begin
                           list_wr_a  = 1'b1;
                           count_a_in = count_a_ff + CW'(1);
                        end
                     end else begin
                        list_wr_addr = count_b_ff[IW-1:0];
                        if (count_b_ff < CW'(MAX_ITEMS)) begin
                           list_wr_b  = 1'b1;
                           count_b_in = count_b_ff + CW'(1);
                        end
                     end
                     heap_size_in = '0;
                     emitted_in   = '0;
                     sorted_in    = 1'b0;
                  end
                  kss_pkg::OP_TAKE: begin
                     pend_in = '0;
                     seed_in = 1'b0;
                     if (!sorted_ff) begin
                        sorted_in = 1'b1;
                        sel_b_in  = 1'b0;
                        sk_in     = CW'(1);
                        state_in  = ST_SORT_RD;
                     end else begin
                        state_in = ST_CHECK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SORT_RD: begin
            a_rd_addr = sk_ff[IW-1:0];
            b_rd_addr = sk_ff[IW-1:0];
            if (sk_ff >= cnt_sel) begin
               if (!sel_b_ff) begin
                  sel_b_in = 1'b1;
                  sk_in    = CW'(1);
               end else begin
                  state_in = ST_SEED;
               end
            end else begin
               state_in = ST_SORT_GET;
            end
         end
         ST_SORT_GET: begin
            sx_in     = sdata;
            sm_in     = sk_ff[IW-1:0];
            a_rd_addr = sk_ff[IW-1:0] - IW'(1);
            b_rd_addr = sk_ff[IW-1:0] - IW'(1);
            state_in  = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            list_wr_a = !sel_b_ff;
            list_wr_b = sel_b_ff;
            a_rd_addr = sm_ff - IW'(2);
            b_rd_addr = sm_ff - IW'(2);
            if (sdata > sx_ff) begin
               list_wr_data = sdata;
               sm_in        = sm_ff - IW'(1);
               if (sm_ff == IW'(1)) begin
                  state_in = ST_SORT_PUT;
               end
            end else begin
               sk_in    = sk_ff + CW'(1);
               state_in = ST_SORT_RD;
            end
         end
         ST_SORT_PUT: begin
            list_wr_a = !sel_b_ff;
            list_wr_b = sel_b_ff;
            sk_in     = sk_ff + CW'(1);
            state_in  = ST_SORT_RD;
         end
         ST_SEED: begin
            if (n_pairs != '0) begin
               pi_in    = '0;
               pj_in    = '0;
               seed_in  = 1'b1;
               state_in = ST_PUSH_RD;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (n_pairs == '0 || emitted_ff >= n_pairs || heap_size_ff == '0) begin
               res_status_in = 1'b1;
               state_in      = ST_RSP;
            end else begin
               state_in = ST_POP_RD0;
            end
         end
         ST_POP_RD0: begin
            heap_rd_addr = '0;
            state_in     = ST_POP_RDL;
         end
         ST_POP_RDL: begin
            top_in       = heap_rd;
            heap_rd_addr = HAW'(heap_size_ff - HSW'(1));
            state_in     = ST_POP_LAST;
         end
         ST_POP_LAST: begin
            e_in          = heap_rd;
            k_in          = '0;
            heap_size_in  = heap_size_ff - HSW'(1);
            res_status_in = 1'b0;
            res_rank_in   = kss_pkg::RANK_W'(emitted_ff);
            res_last_in   = ((CW+1)'(emitted_ff) + (CW+1)'(1)) == (CW+1)'(n_pairs);
            emitted_in    = emitted_ff + CW'(1);
            pend_in[0]    = (top_ff.j == '0) && ((CW+1)'(top_ff.i) + (CW+1)'(1) <
                                                 (CW+1)'(count_a_ff));
            pend_in[1]    = ((CW+1)'(top_ff.j) + (CW+1)'(1)) < (CW+1)'(count_b_ff);
            state_in      = (heap_size_ff == HSW'(1)) ? ST_PUSH_SEL : ST_POP_C1;
         end
         ST_POP_C1: begin
            c_in         = child1;
            heap_rd_addr = child1[HAW-1:0];
            if (child1 >= size_ext) begin
               heap_wr_en = 1'b1;
               state_in   = ST_PUSH_SEL;
            end else begin
               state_in = ST_POP_C1D;
            end
         end
         ST_POP_C1D, ST_POP_C2D: begin
            c1_in        = heap_rd;
            heap_rd_addr = HAW'(c_ff + (HAW+2)'(1));
            if (state_ff == ST_POP_C1D && (c_ff + (HAW+2)'(1)) < size_ext) begin
               state_in = ST_POP_C2D;
            end else if (entry_less(best, e_ff)) begin
               heap_wr_en   = 1'b1;
               heap_wr_data = best;
               k_in         = best_c[HAW-1:0];
               state_in     = ST_POP_C1;
            end else begin
               heap_wr_en = 1'b1;
               state_in   = ST_PUSH_SEL;
            end
         end
         ST_PUSH_SEL: begin
            if (pend_ff[0]) begin
               pi_in      = top_ff.i + IW'(1);
               pj_in      = top_ff.j;
               pend_in[0] = 1'b0;
               state_in   = ST_PUSH_RD;
            end else if (pend_ff[1]) begin
               pi_in      = top_ff.i;
               pj_in      = top_ff.j + IW'(1);
               pend_in[1] = 1'b0;
               state_in   = ST_PUSH_RD;
            end else if (seed_ff) begin
               seed_in  = 1'b0;
               state_in = ST_CHECK;
            end else begin
               state_in = ST_RSP;
            end
         end
         ST_PUSH_RD: begin
            state_in = ST_PUSH_SUM;
         end
         ST_PUSH_SUM: begin
            e_in         = push_e;
            k_in         = HAW'(heap_size_ff);
            heap_size_in = heap_size_ff + HSW'(1);
            heap_wr_addr = HAW'(heap_size_ff);
            heap_wr_data = push_e;
            heap_rd_addr = HAW'((heap_size_ff - HSW'(1)) >> 1);
            if (heap_size_ff == '0) begin
               heap_wr_en = 1'b1;
               state_in   = ST_PUSH_SEL;
            end else begin
               state_in = ST_PUSH_CMP;
            end
         end
         ST_PUSH_CMP: begin
            heap_wr_en   = 1'b1;
            heap_rd_addr = HAW'((parent_k - HAW'(1)) >> 1);
            if (entry_less(e_ff, heap_rd)) begin
               heap_wr_data = heap_rd;
               k_in         = parent_k;
               if (parent_k == '0) begin
                  state_in = ST_PUSH_PUT;
               end
            end else begin
               state_in = ST_PUSH_SEL;
            end
         end
         ST_PUSH_PUT: begin
            heap_wr_en = 1'b1;
            state_in   = ST_PUSH_SEL;
         end
         ST_RSP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sum_in    = res_status_ff ? '0 : top_ff.s;
               rsp_rank_in   = res_status_ff ? '0 : res_rank_ff;
               rsp_last_in   = res_status_ff ? 1'b0 : res_last_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         emitted_ff   <= '0;
         heap_size_ff <= '0;
         sorted_ff    <= 1'b0;
         seed_ff      <= 1'b0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         emitted_ff   <= emitted_in;
         heap_size_ff <= heap_size_in;
         sorted_ff    <= sorted_in;
         seed_ff      <= seed_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_b_ff      <= sel_b_in;
      sk_ff         <= sk_in;
      sm_ff         <= sm_in;
      sx_ff         <= sx_in;
      pi_ff         <= pi_in;
      pj_ff         <= pj_in;
      k_ff          <= k_in;
      e_ff          <= e_in;
      top_ff        <= top_in;
      c1_ff         <= c1_in;
      c_ff          <= c_in;
      res_status_ff <= res_status_in;
      res_last_ff   <= res_last_in;
      res_rank_ff   <= res_rank_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_rank   = rsp_rank_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   // one heap entry per row of list a at most
   a_heap_bound: assert property (@(posedge clock) disable iff (reset)
      (CW+1)'(heap_size_ff) <= (CW+1)'(count_a_ff))
      else $error("heap holds more entries than rows");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= n_pairs)
      else $error("more sums emitted than pairs available");

   a_exhausted_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> rsp_sum_ff == '0 && !rsp_last_ff && rsp_rank_ff == '0)
      else $error("exhausted transaction carries payload");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RSP))
      else $error("response raised outside response state");

endmodule
